// ===== hdl/ralt_pkg.sv =====
// ----------------------------------------------------------------------------
// ralt_pkg: shared types and constants of the range admission lock table
// Beat layouts, request and status codes, the cell record and the overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package ralt_pkg;

   localparam int ADDR_BITS = 48;
   localparam int LEN_BITS  = 24;
   localparam int SLOT_W    = 3;
   localparam int KIND_W    = 2;
   localparam int STAT_W    = 2;

   localparam logic [KIND_W-1:0] REQ_ENTER = 2'd0;
   localparam logic [KIND_W-1:0] REQ_LEAVE = 2'd1;
   localparam logic [KIND_W-1:0] REQ_QUERY = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]    req_type;
      logic [SLOT_W-1:0]    slot_id;
      logic [ADDR_BITS-1:0] range_start;
      logic [LEN_BITS-1:0]  range_length;
      logic                 exclusive;
   } req_beat_type;

   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic              blocked;
      logic [STAT_W-1:0] status;
      logic              wake;
   } rsp_beat_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] range_start;
      logic [LEN_BITS-1:0]  range_length;
      logic                 exclusive;
   } entry_type;

   // Probe record that walks the ring of cells.
   typedef struct packed {
      logic      valid;
      logic      blocked;
      entry_type subject;
   } probe_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic inject;
      logic write;
      logic leave;
      logic use_own;
      logic advance;
      logic flush;
   } cell_ctrl_type;

   function automatic logic ranges_meet(input entry_type a, input entry_type b);
      logic [ADDR_BITS-1:0] d_ab;
      logic [ADDR_BITS-1:0] d_ba;
      logic [ADDR_BITS-1:0] a_len;
      logic [ADDR_BITS-1:0] b_len;
      logic                 meet;
      d_ab  = b.range_start - a.range_start;
      d_ba  = a.range_start - b.range_start;
      a_len = {{(ADDR_BITS-LEN_BITS){1'b0}}, a.range_length};
      b_len = {{(ADDR_BITS-LEN_BITS){1'b0}}, b.range_length};
      if (a.range_length == '0 || b.range_length == '0) begin
         meet = 1'b0;
      end else if (a.range_start <= b.range_start) begin
         meet = (d_ab < a_len);
      end else begin
         meet = (d_ba < b_len);
      end
      return meet;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ralt_cell.sv =====
// ----------------------------------------------------------------------------
// ralt_cell: one slot of the lock table
// Holds one range, its valid bit and its arrival mask, and checks the probe
// that passes through against its own range before handing it on.
// ----------------------------------------------------------------------------
`default_nettype none

module ralt_cell #(
   parameter int SLOTS = 8,
   parameter int IDX   = 0
) (
   input  wire                      clock,
   input  wire                      reset,
   input  ralt_pkg::cell_ctrl_type  ctrl,
   input  wire  [SLOTS-1:0]         active,
   input  wire  [SLOTS-1:0]         leave_mask,
   input  ralt_pkg::entry_type      req_range,
   input  ralt_pkg::probe_type      probe_in,
   input  wire  [SLOTS-1:0]         mask_in,
   output ralt_pkg::probe_type      probe_out,
   output logic [SLOTS-1:0]         mask_out,
   output logic                     valid_out
);

   logic                valid_ff, valid_in;
   logic [SLOTS-1:0]    older_ff, older_in;
   ralt_pkg::entry_type range_ff, range_in;
   ralt_pkg::probe_type probe_ff, probe_in_d;
   logic [SLOTS-1:0]    pmask_ff, pmask_in;

   ralt_pkg::probe_type src;
   logic [SLOTS-1:0]    src_mask;
   logic                hit;

   always_comb begin
      // Take a fresh probe here, or the one from the neighbor.
      if (ctrl.inject) begin
         src.valid   = 1'b1;
         src.blocked = 1'b0;
         src.subject = ctrl.use_own ? range_ff : req_range;
         src_mask    = ctrl.use_own ? older_ff : active;
      end else begin
         src      = probe_in;
         src_mask = mask_in;
      end

      hit = src.valid && src_mask[IDX] && valid_ff &&
            (src.subject.exclusive || range_ff.exclusive) &&
            ralt_pkg::ranges_meet(src.subject, range_ff);

      valid_in = valid_ff;
      older_in = older_ff & ~leave_mask;
      range_in = range_ff;
      if (ctrl.write) begin
         valid_in = 1'b1;
         older_in = active;
         range_in = req_range;
      end else if (ctrl.leave) begin
         valid_in = 1'b0;
         older_in = '0;
      end

      probe_in_d = probe_ff;
      pmask_in   = pmask_ff;
      if (ctrl.flush) begin
         probe_in_d.valid = 1'b0;
      end else if (ctrl.inject || ctrl.advance) begin
         probe_in_d         = src;
         probe_in_d.blocked = src.blocked || hit;
         pmask_in           = src_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         older_ff       <= '0;
         probe_ff.valid <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         older_ff       <= older_in;
         probe_ff.valid <= probe_in_d.valid;
      end
      range_ff         <= range_in;
      probe_ff.blocked <= probe_in_d.blocked;
      probe_ff.subject <= probe_in_d.subject;
      pmask_ff         <= pmask_in;
   end

   assign probe_out = probe_ff;
   assign mask_out  = pmask_ff;
   assign valid_out = valid_ff;

endmodule

`default_nettype wire

// ===== hdl/range_admission_lock_table.sv =====
// ----------------------------------------------------------------------------
// range_admission_lock_table: admission control for active byte ranges
// Ring of slot cells with a sequencer that injects and walks a conflict probe.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one request beat: enter a range, leave
//   a slot or query a slot. rsp_valid/rsp_ready/rsp_data return exactly one
//   result beat per request, in request order.
//   Enter and query inject a probe into the ring at the target cell; the probe
//   moves one cell per cycle and is checked by every cell it passes, so the
//   result is registered once the probe has gone round the ring. Leave,
//   a full table, an inactive slot and unused codes skip the walk and answer
//   straight from the pending registers.
//   One request is in work at a time: the next request is taken only once
//   the current result has been loaded into the output register, so enter
//   and query are paced by the walk of the probe around the ring.
//   The output register lets a new request be taken while a result waits;
//   a stalled receiver holds rsp_data and, once the next result is ready,
//   also holds req_ready low.
//   Synchronous reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module range_admission_lock_table #(
   parameter int SLOTS = 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  ralt_pkg::req_beat_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output ralt_pkg::rsp_beat_type  rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                        busy_ff, busy_in;
   logic                        probing_ff, probing_in;
   logic [IDX_W-1:0]            hop_ff, hop_in;
   logic [ralt_pkg::SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [ralt_pkg::STAT_W-1:0] pend_status_ff, pend_status_in;
   logic                        pend_wake_ff, pend_wake_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ralt_pkg::rsp_beat_type      rsp_ff, rsp_in;

   logic [SLOTS-1:0] active, free_vec, free_onehot, sid_onehot;
   logic [SLOTS-1:0] inject_oh, write_oh, leave_mask;
   logic [IDX_W-1:0] free_idx;
   logic             full, sid_active, use_own;
   logic             req_fire, finish, rsp_load, advance, chain_blocked;

   ralt_pkg::cell_ctrl_type ctrl    [SLOTS];
   ralt_pkg::probe_type     probe_q [SLOTS];
   logic [SLOTS-1:0]        mask_q  [SLOTS];
   ralt_pkg::entry_type     req_range;

   assign req_range.range_start  = req_data.range_start;
   assign req_range.range_length = req_data.range_length;
   assign req_range.exclusive    = req_data.exclusive;

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign finish    = busy_ff && (!probing_ff || hop_ff == '0);
   assign rsp_load  = finish && (!rsp_valid_ff || rsp_ready);
   assign advance   = busy_ff && probing_ff && hop_ff != '0;

   // Lowest free slot, slot-id decode and the blocked flag of the ring.
   always_comb begin
      free_vec    = ~active;
      free_onehot = free_vec & (~free_vec + SLOTS'(1));
      full        = ~|free_vec;
      free_idx    = '0;
      chain_blocked = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (free_onehot[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
         sid_onehot[i] = (int'(req_data.slot_id) == i);
         chain_blocked = chain_blocked || (probe_q[i].valid && probe_q[i].blocked);
      end
      sid_active = |(sid_onehot & active);
   end

   // Decode the request beat and step the sequencer.
   always_comb begin
      inject_oh      = '0;
      write_oh       = '0;
      leave_mask     = '0;
      use_own        = 1'b0;
      busy_in        = busy_ff;
      probing_in     = probing_ff;
      hop_in         = hop_ff;
      pend_slot_in   = pend_slot_ff;
      pend_status_in = pend_status_ff;
      pend_wake_in   = pend_wake_ff;

      if (advance) begin
         hop_in = hop_ff - IDX_W'(1);
      end
      if (rsp_load) begin
         busy_in    = 1'b0;
         probing_in = 1'b0;
      end

      if (req_fire) begin
         busy_in        = 1'b1;
         probing_in     = 1'b0;
         hop_in         = IDX_W'(SLOTS - 1);
         pend_slot_in   = req_data.slot_id;
         pend_status_in = ralt_pkg::ST_OK;
         pend_wake_in   = 1'b0;
         case (req_data.req_type)
            ralt_pkg::REQ_ENTER: begin
               if (full) begin
                  pend_slot_in   = '0;
                  pend_status_in = ralt_pkg::ST_FULL;
               end else begin
                  inject_oh    = free_onehot;
                  write_oh     = free_onehot;
                  probing_in   = 1'b1;
                  pend_slot_in = ralt_pkg::SLOT_W'(free_idx);
               end
            end
            ralt_pkg::REQ_LEAVE: begin
               if (!sid_active) begin
                  pend_status_in = ralt_pkg::ST_INACTIVE;
               end else begin
                  leave_mask   = sid_onehot;
                  pend_wake_in = 1'b1;
               end
            end
            ralt_pkg::REQ_QUERY: begin
               if (!sid_active) begin
                  pend_status_in = ralt_pkg::ST_INACTIVE;
               end else begin
                  inject_oh  = sid_onehot;
                  use_own    = 1'b1;
                  probing_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.granted_slot = pend_slot_ff;
         rsp_in.blocked      = probing_ff && chain_blocked;
         rsp_in.status       = pend_status_ff;
         rsp_in.wake         = pend_wake_ff;
      end
   end

   generate
      for (genvar g = 0; g < SLOTS; g++) begin : g_cell
         localparam int PREV = (g + SLOTS - 1) % SLOTS;

         assign ctrl[g].inject  = inject_oh[g];
         assign ctrl[g].write   = write_oh[g];
         assign ctrl[g].leave   = leave_mask[g];
         assign ctrl[g].use_own = use_own;
         assign ctrl[g].advance = advance;
         assign ctrl[g].flush   = rsp_load;

         ralt_cell #(
            .SLOTS (SLOTS),
            .IDX   (g)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl[g]),
            .active     (active),
            .leave_mask (leave_mask),
            .req_range  (req_range),
            .probe_in   (probe_q[PREV]),
            .mask_in    (mask_q[PREV]),
            .probe_out  (probe_q[g]),
            .mask_out   (mask_q[g]),
            .valid_out  (active[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         probing_ff   <= 1'b0;
         hop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         probing_ff   <= probing_in;
         hop_ff       <= hop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_slot_ff   <= pend_slot_in;
      pend_status_ff <= pend_status_in;
      pend_wake_ff   <= pend_wake_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/ralt_checker.sv =====
// ----------------------------------------------------------------------------
// ralt_checker: port-level checks of the range admission lock table
// Watches the request and result channels and flags inconsistent beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ralt_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_valid,
   input wire                     req_ready,
   input ralt_pkg::req_beat_type  req_data,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input ralt_pkg::rsp_beat_type  rsp_data
);

   // Hold a stalled result beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result beat changed while stalled");

   // One request in work: a taken request closes the input.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in work");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ralt_pkg::ST_FULL) |->
      (rsp_data.granted_slot == '0 && !rsp_data.blocked && !rsp_data.wake))
      else $error("table full result carries slot, blocked or wake");

   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.wake) |->
      (rsp_data.status == ralt_pkg::ST_OK && !rsp_data.blocked))
      else $error("wake raised on a failed or blocked result");

   a_inactive_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ralt_pkg::ST_INACTIVE) |->
      (!rsp_data.blocked && !rsp_data.wake))
      else $error("inactive slot result carries blocked or wake");

endmodule

bind range_admission_lock_table ralt_checker u_ralt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
